// File: hdl/vbam_pkg.sv
// Shared types and constants of the VRAM bank address mapper.
// No dependencies; every other file of the block imports this package.
package vbam_pkg;

    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 20;
    localparam int OFFSET_W = 20;
    localparam int PAGE_W   = 6;
    localparam int WITHIN_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Bus views carried in the kind field.
    localparam logic [KIND_W-1:0] VIEW_LCDC  = 3'd0;
    localparam logic [KIND_W-1:0] VIEW_A_BG  = 3'd1;
    localparam logic [KIND_W-1:0] VIEW_A_OBJ = 3'd2;
    localparam logic [KIND_W-1:0] VIEW_B_BG  = 3'd3;
    localparam logic [KIND_W-1:0] VIEW_B_OBJ = 3'd4;
    localparam logic [KIND_W-1:0] VIEW_ARM7  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CTL_ABCD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTL_EFG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTL_HI   = 2'd2;

    // Bank modes.
    localparam logic [2:0] MODE_LCDC = 3'd0;
    localparam logic [2:0] MODE_ONE  = 3'd1;
    localparam logic [2:0] MODE_TWO  = 3'd2;
    localparam logic [2:0] MODE_FOUR = 3'd4;

    // Physical base of the small banks, in 16 KB pages.
    localparam logic [PAGE_W-1:0] PAGE_E = 6'h20;
    localparam logic [PAGE_W-1:0] PAGE_F = 6'h24;
    localparam logic [PAGE_W-1:0] PAGE_G = 6'h25;
    localparam logic [PAGE_W-1:0] PAGE_H = 6'h26;
    localparam logic [PAGE_W-1:0] PAGE_I = 6'h28;

    // Highest offset that any mapping can produce.
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 20'hA3FFF;

    typedef struct packed {
        logic [31:0] ctl_abcd;
        logic [23:0] ctl_efg;
        logic [15:0] ctl_hi;
    } bank_cfg_t;

endpackage

// File: hdl/vbam_cfg_regs.sv
// Bank control register file of the VRAM bank address mapper.
// Depends on vbam_pkg for register indexes and the bank_cfg_t type.
module vbam_cfg_regs
    import vbam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bank_cfg_t             cfg
);

    bank_cfg_t cfg_reg;
    bank_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CTL_ABCD: cfg_next.ctl_abcd = cfg_data;
                REG_CTL_EFG:  cfg_next.ctl_efg  = cfg_data[23:0];
                REG_CTL_HI:   cfg_next.ctl_hi   = cfg_data[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/vbam_lookup.sv
// Page lookup of the VRAM bank address mapper: banks A to I are checked
// against the addressed page, a later bank winning. Depends on vbam_pkg.
module vbam_lookup
    import vbam_pkg::*;
(
    input  bank_cfg_t             cfg,
    input  logic [KIND_W-1:0]     kind,
    input  logic [ADDR_W-1:0]     bus_address,
    output logic [OFFSET_W-1:0]   vram_offset,
    output logic                  unmapped
);

    logic [PAGE_W-1:0]   page;
    logic                region;
    logic [WITHIN_W-1:0] in_page;
    logic                hit;
    logic [PAGE_W-1:0]   base_page;
    logic [7:0]          ctl;
    logic [2:0]          mode;
    logic [1:0]          ofs;

    always_comb begin
        region  = bus_address[17];
        in_page = {3'b000, bus_address[13:0]};
        case (kind)
            VIEW_LCDC:  page = bus_address[19:14];
            VIEW_A_BG:  page = {1'b0, bus_address[18:14]};
            VIEW_A_OBJ: page = {2'b00, bus_address[17:14]};
            VIEW_ARM7: begin
                page    = '0;
                in_page = bus_address[16:0];
            end
            default:    page = {3'b000, bus_address[16:14]};
        endcase
    end

    always_comb begin
        hit       = 1'b0;
        base_page = '0;
        ctl       = '0;
        mode      = '0;
        ofs       = '0;

        // Banks A to D.
        for (int b = 0; b < 4; b++) begin
            ctl  = cfg.ctl_abcd[8*b +: 8];
            mode = (b < 2) ? {1'b0, ctl[1:0]} : ctl[2:0];
            ofs  = ctl[4:3];
            case (kind)
                VIEW_LCDC: begin
                    if (mode == MODE_LCDC && page[5:3] == 3'(b)) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), page[2:0]};
                    end
                end
                VIEW_A_BG: begin
                    if (mode == MODE_ONE && page[4:3] == ofs) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), page[2:0]};
                    end
                end
                VIEW_A_OBJ: begin
                    if (mode == MODE_TWO && b < 2 && page[3] == ofs[0]) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), page[2:0]};
                    end
                end
                VIEW_ARM7: begin
                    if (mode == MODE_TWO && b >= 2 && region == ofs[0]) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), 3'b000};
                    end
                end
                VIEW_B_BG: begin
                    if (mode == MODE_FOUR && b == 2) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), page[2:0]};
                    end
                end
                VIEW_B_OBJ: begin
                    if (mode == MODE_FOUR && b == 3) begin
                        hit = 1'b1;
                        base_page = {1'b0, 2'(b), page[2:0]};
                    end
                end
                default: begin
                end
            endcase
        end

        // Bank E.
        mode = cfg.ctl_efg[2:0];
        if ((kind == VIEW_LCDC && mode == MODE_LCDC && page[5:2] == 4'b1000)
            || (kind == VIEW_A_BG && mode == MODE_ONE && page[4:2] == 3'b000)
            || (kind == VIEW_A_OBJ && mode == MODE_TWO && page[3:2] == 2'b00)) begin
            hit = 1'b1;
            base_page = PAGE_E + {4'b0000, page[1:0]};
        end

        // Banks F and G each fill page p and its mirror p | 2.
        for (int b = 0; b < 2; b++) begin
            ctl  = cfg.ctl_efg[8*(b+1) +: 8];
            mode = ctl[2:0];
            ofs  = ctl[4:3];
            if ((kind == VIEW_LCDC && mode == MODE_LCDC && page == PAGE_F + 6'(b))
                || (kind == VIEW_A_BG && mode == MODE_ONE && page[4:3] == 2'b00
                    && page[2] == ofs[1] && page[0] == ofs[0])
                || (kind == VIEW_A_OBJ && mode == MODE_TWO && page[3] == 1'b0
                    && page[2] == ofs[1] && page[0] == ofs[0])) begin
                hit = 1'b1;
                base_page = (b == 0) ? PAGE_F : PAGE_G;
            end
        end

        // Bank H, mirrored into background pages 4 and 5.
        mode = {1'b0, cfg.ctl_hi[1:0]};
        if ((kind == VIEW_LCDC && mode == MODE_LCDC && page[5:1] == 5'h13)
            || (kind == VIEW_B_BG && mode == MODE_ONE && page[1] == 1'b0)) begin
            hit = 1'b1;
            base_page = PAGE_H + {5'b00000, page[0]};
        end

        // Bank I. LCDC pages beyond it are matched by no bank.
        mode = {1'b0, cfg.ctl_hi[9:8]};
        if ((kind == VIEW_LCDC && mode == MODE_LCDC && page == PAGE_I)
            || (kind == VIEW_B_BG && mode == MODE_ONE && page[2:0] == 3'd2)
            || (kind == VIEW_B_OBJ && mode == MODE_TWO)) begin
            hit = 1'b1;
            base_page = PAGE_I;
        end
    end

    assign unmapped    = !hit;
    assign vram_offset = hit ? ({base_page, 14'b0} + {3'b000, in_page}) : '0;

endmodule

// File: hdl/vram_bank_address_mapper_top.sv
// Channel   Ports                                       Direction
// config    cfg_valid cfg_ready cfg_index cfg_data      in (ready always high)
// request   s_valid s_ready s_kind s_bus_address        in
// result    m_valid m_ready m_vram_offset m_unmapped    out
//
// One item is accepted per cycle while s_ready is high; its result passes from the
// request register through the lookup into the result register and the m_ ports.
// Reset (aresetn low, synchronous) clears both valid flags and the bank controls.
// A stalled result holds the result register; the request register still takes
// an item while it is empty or the result register has space or is being emptied.
// Top level of the VRAM bank address mapper; depends on vbam_pkg,
// vbam_cfg_regs and vbam_lookup.
module vram_bank_address_mapper_top
    import vbam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [ADDR_W-1:0]     s_bus_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OFFSET_W-1:0]   m_vram_offset,
    output logic                  m_unmapped
);

    bank_cfg_t             cfg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [KIND_W-1:0]     kind_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     addr_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [OFFSET_W-1:0]   offset_next;
    logic                  unmapped_reg;
    logic                  unmapped_next;
    logic [OFFSET_W-1:0]   lookup_offset;
    logic                  lookup_unmapped;
    logic                  out_free;

    assign cfg_ready = 1'b1;

    vbam_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vbam_lookup u_lookup (
        .cfg         (cfg),
        .kind        (kind_reg),
        .bus_address (addr_reg),
        .vram_offset (lookup_offset),
        .unmapped    (lookup_unmapped)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        offset_next    = offset_reg;
        unmapped_next  = unmapped_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            kind_next     = s_kind;
            addr_next     = s_bus_address;
        end
        if (out_free) begin
            out_valid_next = in_valid_reg;
            offset_next    = lookup_offset;
            unmapped_next  = lookup_unmapped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        offset_reg   <= offset_next;
        unmapped_reg <= unmapped_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_vram_offset = offset_reg;
    assign m_unmapped    = unmapped_reg;

endmodule

// File: hdl/vbam_checker.sv
// Port-level checks of the VRAM bank address mapper and their binding.
// Depends on vbam_pkg and the top level vram_bank_address_mapper_top.
module vbam_checker
    import vbam_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [OFFSET_W-1:0] m_vram_offset,
    input logic                m_unmapped
);

    // The result register is empty straight after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled item keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vram_offset) && $stable(m_unmapped))
        else $error("stalled item changed");

    // An unmapped page always reports offset zero.
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unmapped |-> m_vram_offset == '0)
        else $error("unmapped item with non-zero offset");

    // No mapping reaches past the end of bank I.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_vram_offset <= OFFSET_MAX)
        else $error("offset beyond physical VRAM");

    // The request side never stalls while the result side is being drained.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("request stalled with free result register");

endmodule

bind vram_bank_address_mapper_top vbam_checker u_vbam_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_vram_offset (m_vram_offset),
    .m_unmapped    (m_unmapped)
);
